// ===== sv/api_pkg.sv =====
// ----------------------------------------------------------------------------
// api_pkg
// Shared types and constants for the alignment percent identity block.
// ----------------------------------------------------------------------------
package api_pkg;

    localparam int CNT_W       = 16;
    localparam int PCT_W       = 15;
    localparam int CHAR_W      = 8;
    localparam int NUM_W       = CNT_W + PCT_W;
    localparam int DIV_STEPS   = PCT_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    localparam logic [CHAR_W-1:0] GAP_CHAR = 8'd45;

    localparam int MAX_COLUMNS = 65535;
    localparam int SAT_LIMIT_I = (MAX_COLUMNS < 65535) ? MAX_COLUMNS : 65535;
    localparam logic [CNT_W-1:0] SAT_LIMIT = SAT_LIMIT_I[CNT_W-1:0];

    // 100 percent with 8 fraction bits
    localparam int PCT_SCALE_I = 25600;
    localparam logic [PCT_W-1:0] PCT_SCALE = PCT_SCALE_I[PCT_W-1:0];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic done;
    } t_div_stat;

endpackage

// ===== sv/api_divider.sv =====
// ----------------------------------------------------------------------------
// api_divider
// Restoring divider, one quotient bit per cycle through one shared subtractor.
// The quotient is known to fit in PCT_W bits, so the numerator's top CNT_W
// bits seed the remainder and only PCT_W steps are needed.
// ----------------------------------------------------------------------------
module api_divider
    import api_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctrl        i_ctrl,
    input  logic [NUM_W-1:0] i_numer,
    input  logic [CNT_W-1:0] i_denom,
    output t_div_stat        o_stat,
    output logic [PCT_W-1:0] o_quotient
);

    logic [CNT_W-1:0]  r_rem;
    logic [PCT_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_done;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              q_bit;

    always_comb begin
        trial = {r_rem, r_quo[PCT_W-1]};
        diff  = trial - {1'b0, i_denom};
        q_bit = (trial >= {1'b0, i_denom});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_cnt <= STEP_W'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == STEP_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= i_numer[NUM_W-1:PCT_W];
            r_quo <= i_numer[PCT_W-1:0];
        end else if (r_cnt != '0) begin
            // shift the next numerator bit in, retire one quotient bit
            r_rem <= q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[PCT_W-2:0], q_bit};
        end
    end

    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// ===== sv/alignment_percent_identity.sv =====
// ----------------------------------------------------------------------------
// alignment_percent_identity
// Streams aligned columns and reports match, mismatch and column counts and
// the percent identity of the alignment.
// ----------------------------------------------------------------------------
// A column that is not the last is taken and the block stays ready for the
// next. The last column starts the percent computation: the 16x15 scale
// multiply in ST_MUL, then the restoring divider, which retires one quotient
// bit a cycle on a single shared subtractor, and then the result load from
// ST_DONE. Input ready is low for that whole time. The result sits in an
// output register, so columns of the next alignment are taken while it
// waits; a new last column waits for the output register before its result
// loads. The ignore_gaps register (reset 1) is always ready for a write.
// ----------------------------------------------------------------------------
module alignment_percent_identity
    import api_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_ignore_gaps,
    // column input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CHAR_W-1:0] i_row_a_char,
    input  logic [CHAR_W-1:0] i_row_b_char,
    input  logic              i_final_column,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [PCT_W-1:0]  o_identity_percent,
    output logic [CNT_W-1:0]  o_match_total,
    output logic [CNT_W-1:0]  o_mismatch_total,
    output logic [CNT_W-1:0]  o_aligned_total
);

    function automatic logic [CNT_W-1:0] sat(input logic [CNT_W+1:0] s);
        return (s > {2'b00, SAT_LIMIT}) ? SAT_LIMIT : s[CNT_W-1:0];
    endfunction

    t_state r_state, n_state;

    logic             r_ignore_gaps;
    logic             r_inside;
    logic [CNT_W-1:0] r_match, r_mismatch, r_column;
    logic [CNT_W-1:0] r_pend_match, r_pend_mismatch;

    logic [CNT_W-1:0] r_div_match, r_div_mismatch, r_div_column;

    logic             r_out_valid;
    logic [PCT_W-1:0] r_out_pct;
    logic [CNT_W-1:0] r_out_match, r_out_mismatch, r_out_column;

    logic             in_take;
    logic             gap, same;
    logic [CNT_W-1:0] n_match, n_mismatch, n_column;
    logic [CNT_W-1:0] n_pend_match, n_pend_mismatch;
    logic             n_inside;
    logic             load_out;

    t_div_ctrl        div_ctrl;
    t_div_stat        div_stat;
    logic [NUM_W-1:0] div_numer;
    logic [PCT_W-1:0] div_quo;

    assign o_cfg_ready = 1'b1;
    assign in_take     = i_in_valid && o_in_ready;

    // column update
    always_comb begin
        gap  = (i_row_a_char == GAP_CHAR) || (i_row_b_char == GAP_CHAR);
        same = (i_row_a_char == i_row_b_char);

        n_match         = r_match;
        n_mismatch      = r_mismatch;
        n_column        = r_column;
        n_pend_match    = r_pend_match;
        n_pend_mismatch = r_pend_mismatch;
        n_inside        = r_inside;

        if (!gap) begin
            // a gap-free column confirms the held gap columns
            n_match    = sat({2'b00, r_match} + {2'b00, r_pend_match}
                             + {{(CNT_W+1){1'b0}}, same});
            n_mismatch = sat({2'b00, r_mismatch} + {2'b00, r_pend_mismatch}
                             + {{(CNT_W+1){1'b0}}, !same});
            n_column   = sat({2'b00, r_column} + {2'b00, r_pend_match}
                             + {2'b00, r_pend_mismatch} + (CNT_W+2)'(1));
            n_pend_match    = '0;
            n_pend_mismatch = '0;
            n_inside        = 1'b1;
        end else if (r_inside && !r_ignore_gaps) begin
            if (same) begin
                n_pend_match = sat({2'b00, r_pend_match} + (CNT_W+2)'(1));
            end else begin
                n_pend_mismatch = sat({2'b00, r_pend_mismatch} + (CNT_W+2)'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_gaps <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ignore_gaps <= i_cfg_ignore_gaps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside        <= 1'b0;
            r_match         <= '0;
            r_mismatch      <= '0;
            r_column        <= '0;
            r_pend_match    <= '0;
            r_pend_mismatch <= '0;
        end else if (in_take) begin
            if (i_final_column) begin
                // totals move to the divide stage, start a fresh alignment
                r_inside        <= 1'b0;
                r_match         <= '0;
                r_mismatch      <= '0;
                r_column        <= '0;
                r_pend_match    <= '0;
                r_pend_mismatch <= '0;
            end else begin
                r_inside        <= n_inside;
                r_match         <= n_match;
                r_mismatch      <= n_mismatch;
                r_column        <= n_column;
                r_pend_match    <= n_pend_match;
                r_pend_mismatch <= n_pend_mismatch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_final_column) begin
            r_div_match    <= n_match;
            r_div_mismatch <= n_mismatch;
            r_div_column   <= n_column;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        div_ctrl.start = 1'b0;
        load_out       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_final_column) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                div_ctrl.start = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign div_numer = NUM_W'(r_div_match) * NUM_W'(PCT_SCALE);

    api_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_numer    (div_numer),
        .i_denom    (r_div_column),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_pct      <= (r_div_column == '0) ? '0 : div_quo;
            r_out_match    <= r_div_match;
            r_out_mismatch <= r_div_mismatch;
            r_out_column   <= r_div_column;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_identity_percent = r_out_pct;
    assign o_match_total      = r_out_match;
    assign o_mismatch_total   = r_out_mismatch;
    assign o_aligned_total    = r_out_column;

endmodule

// ===== sv/api_checker.sv =====
// ----------------------------------------------------------------------------
// api_checker
// Port-level checks for the alignment percent identity block.
// ----------------------------------------------------------------------------
module api_checker
    import api_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              i_final_column,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [PCT_W-1:0]  o_identity_percent,
    input logic [CNT_W-1:0]  o_match_total,
    input logic [CNT_W-1:0]  o_aligned_total
);

    // a last column blocks input while the percent is worked out
    a_busy_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_final_column) |=> !o_in_ready)
        else $error("input ready right after a last column");

    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_match_total <= o_aligned_total))
        else $error("match total above aligned total");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_identity_percent <= PCT_SCALE))
        else $error("identity percent above 100");

    a_pct_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_aligned_total == '0)) |-> (o_identity_percent == '0))
        else $error("nonzero identity with no counted columns");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_identity_percent) && $stable(o_aligned_total)))
        else $error("stalled result changed");

endmodule

bind alignment_percent_identity api_checker u_api_checker (.*);

// ===== test/tb_alignment_percent_identity.sv =====
// ----------------------------------------------------------------------------
// tb_alignment_percent_identity
// Streams aligned columns into the percent identity block under random
// valid/ready idling and checks every result against a cycle-free predictor
// held in a scoreboard: directed edge cases, then random alignments under
// both gap settings, one phase of them with no idling.
// ----------------------------------------------------------------------------
module tb_alignment_percent_identity;
    timeunit 1ns;
    timeprecision 1ps;

    import api_pkg::*;

    localparam int DRAIN_CYCLES = 24;    // margin for the last result to drain
    localparam int STALL_LIMIT  = 4000;  // cycles without any item moving
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 6;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic [CNT_W-1:0] match_cnt;
        logic [CNT_W-1:0] mismatches;
        logic [CNT_W-1:0] columns;
    } t_identity_result;

    class t_identity_scoreboard;
        bit               ignore_gaps;
        bit               in_region;
        logic [CNT_W-1:0] match_cnt;
        logic [CNT_W-1:0] mismatches;
        logic [CNT_W-1:0] columns;
        logic [CNT_W-1:0] held_matches;
        logic [CNT_W-1:0] held_mismatches;
        t_identity_result expected_q[$];
        int unsigned      errors;
        int unsigned      columns_seen;
        int unsigned      results_checked;
        int unsigned      cfg_writes;

        function new();
            ignore_gaps = 1'b1;
            clear_alignment();
        endfunction

        function void clear_alignment();
            in_region       = 1'b0;
            match_cnt       = '0;
            mismatches      = '0;
            columns         = '0;
            held_matches    = '0;
            held_mismatches = '0;
        endfunction

        function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] x, logic [CNT_W-1:0] y);
            logic [CNT_W:0] sum;
            sum = {1'b0, x} + {1'b0, y};
            return (sum > {1'b0, SAT_LIMIT}) ? SAT_LIMIT : sum[CNT_W-1:0];
        endfunction

        function void note_config(bit value);
            ignore_gaps = value;
            cfg_writes++;
        endfunction

        function void note_column(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b, logic last);
            t_identity_result res;
            logic [31:0]      prod;
            logic [31:0]      quot;
            columns_seen++;
            if (a != GAP_CHAR && b != GAP_CHAR) begin
                // a gap-free column confirms the held gap columns
                match_cnt       = sat_add(match_cnt, held_matches);
                mismatches      = sat_add(mismatches, held_mismatches);
                columns         = sat_add(columns, held_matches);
                columns         = sat_add(columns, held_mismatches);
                held_matches    = '0;
                held_mismatches = '0;
                if (a == b) begin
                    match_cnt = sat_add(match_cnt, CNT_W'(1));
                end else begin
                    mismatches = sat_add(mismatches, CNT_W'(1));
                end
                columns   = sat_add(columns, CNT_W'(1));
                in_region = 1'b1;
            end else if (in_region && !ignore_gaps) begin
                if (a == b) begin
                    held_matches = sat_add(held_matches, CNT_W'(1));
                end else begin
                    held_mismatches = sat_add(held_mismatches, CNT_W'(1));
                end
            end
            if (last) begin
                res.pct = '0;
                if (columns != '0) begin
                    prod    = 32'(match_cnt) * 32'(PCT_SCALE);
                    quot    = prod / 32'(columns);
                    res.pct = quot[PCT_W-1:0];
                end
                res.match_cnt  = match_cnt;
                res.mismatches = mismatches;
                res.columns    = columns;
                expected_q     = {expected_q, res};
                clear_alignment();
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_identity_result got);
            t_identity_result exp;
            results_checked++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: pct=%0d", got.pct));
            end else begin
                exp = expected_q.pop_front();
                if (got.pct != exp.pct)
                    report_mismatch($sformatf("identity_percent got %0d want %0d",
                                              got.pct, exp.pct));
                if (got.match_cnt != exp.match_cnt)
                    report_mismatch($sformatf("match_total got %0d want %0d",
                                              got.match_cnt, exp.match_cnt));
                if (got.mismatches != exp.mismatches)
                    report_mismatch($sformatf("mismatch_total got %0d want %0d",
                                              got.mismatches, exp.mismatches));
                if (got.columns != exp.columns)
                    report_mismatch($sformatf("aligned_total got %0d want %0d",
                                              got.columns, exp.columns));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_ignore_gaps = 1'b1;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [CHAR_W-1:0] i_row_a_char = '0;
    logic [CHAR_W-1:0] i_row_b_char = '0;
    logic              i_final_column = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [PCT_W-1:0]  o_identity_percent;
    logic [CNT_W-1:0]  o_match_total;
    logic [CNT_W-1:0]  o_mismatch_total;
    logic [CNT_W-1:0]  o_aligned_total;

    t_identity_scoreboard sb;
    bit                   idle_on = 1'b1;
    int                   stall_cycles = 0;

    alignment_percent_identity dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_ignore_gaps  (i_cfg_ignore_gaps),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_row_a_char       (i_row_a_char),
        .i_row_b_char       (i_row_b_char),
        .i_final_column     (i_final_column),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_identity_percent (o_identity_percent),
        .o_match_total      (o_match_total),
        .o_mismatch_total   (o_mismatch_total),
        .o_aligned_total    (o_aligned_total)
    );

    always #10 i_clk = ~i_clk;

    // result side: random backpressure, changed on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = idle_on ? ($urandom_range(99) >= 24) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result({o_identity_percent, o_match_total, o_mismatch_total,
                             o_aligned_total});
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] no item moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("alignment_percent_identity test failed");
                $finish;
            end
        end
    end

    task automatic send_column(input logic [CHAR_W-1:0] a, input logic [CHAR_W-1:0] b,
                               input logic last);
        while (idle_on && $urandom_range(99) < 24) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_row_a_char   = a;
        i_row_b_char   = b;
        i_final_column = last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_column(a, b, last);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // hold until every expected result is in, then let the divider settle
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_gap_mode(input bit value);
        i_cfg_valid       = 1'b1;
        i_cfg_ignore_gaps = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char(int gap_pct);
        int r;
        r = $urandom_range(99);
        if (r < gap_pct) return GAP_CHAR;
        r = $urandom_range(99);
        if (r < 60) begin
            case ($urandom_range(3))
                0: return "A";
                1: return "C";
                2: return "G";
                default: return "T";
            endcase
        end
        return CHAR_W'($urandom_range(255));
    endfunction

    initial begin
        int               sent;
        int               len;
        int               gap_pct;
        int               r;
        logic [CHAR_W-1:0] a;
        logic [CHAR_W-1:0] b;

        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: counted gaps off
        write_gap_mode(1'b1);
        send_column("A", "A", 1'b1);
        send_column(GAP_CHAR, "X", 1'b1);
        send_column(GAP_CHAR, GAP_CHAR, 1'b1);
        send_column(8'd0, 8'd255, 1'b0);
        send_column(8'd255, 8'd255, 1'b0);
        send_column(8'd0, 8'd0, 1'b0);
        send_column(8'd255, 8'd0, 1'b1);
        send_column(GAP_CHAR, "A", 1'b0);
        send_column("B", GAP_CHAR, 1'b0);
        send_column("C", "C", 1'b0);
        send_column(GAP_CHAR, GAP_CHAR, 1'b0);
        send_column("D", "E", 1'b0);
        send_column("F", GAP_CHAR, 1'b1);
        wait_drained();

        // directed: gaps inside the region counted, trailing gaps dropped
        write_gap_mode(1'b0);
        send_column(GAP_CHAR, GAP_CHAR, 1'b0);
        send_column("A", "B", 1'b0);
        send_column(GAP_CHAR, GAP_CHAR, 1'b0);
        send_column(GAP_CHAR, "Z", 1'b0);
        send_column("C", "C", 1'b0);
        send_column(GAP_CHAR, GAP_CHAR, 1'b0);
        send_column("X", GAP_CHAR, 1'b1);
        send_column("Z", "Z", 1'b0);
        send_column(GAP_CHAR, GAP_CHAR, 1'b0);
        send_column("Y", "Y", 1'b1);
        wait_drained();

        // random alignments; one phase runs with no idling on either side
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            idle_on = (phase != 2);
            write_gap_mode(phase[0] ^ 1'b1 ^ ($urandom_range(3) == 0));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (phase == 3 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 8)
                    wait_drained();
                r = $urandom_range(99);
                len = (r < 80) ? $urandom_range(20, 1) :
                      (r < 95) ? $urandom_range(120, 21) : 1;
                r = $urandom_range(99);
                gap_pct = (r < 40) ? 10 : (r < 80) ? 25 : (r < 92) ? 60 : 100;
                for (int col = 0; col < len; col++) begin
                    a = pick_char(gap_pct);
                    b = ($urandom_range(99) < 40) ? a : pick_char(gap_pct);
                    send_column(a, b, col == len - 1);
                end
                sent += len;
            end
            wait_drained();
        end
        idle_on = 1'b1;

        wait_drained();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        $display("Checked %0d results from %0d columns with %0d gap-mode writes,",
                 sb.results_checked, sb.columns_seen, sb.cfg_writes);
        $display("including empty, all-gap and trailing-gap alignments.");
        if (sb.errors == 0) begin
            $display("alignment_percent_identity test passed");
        end else begin
            $display("alignment_percent_identity test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/api_pkg.sv
sv/api_divider.sv
sv/alignment_percent_identity.sv
sv/api_checker.sv
test/tb_alignment_percent_identity.sv
